@@ hdl/gzmbf_pkg.sv @@
package gzmbf_pkg;

	// default width of the running byte offset
	localparam int OFFSET_BITS_DEFAULT = 32;

	// header constants
	localparam logic [7:0] MAGIC0      = 8'h1f;
	localparam logic [7:0] MAGIC1      = 8'h8b;
	localparam logic [7:0] METHOD_DEFL = 8'h08;
	localparam logic [3:0] FIXED_FLAGS = 4'd3;
	localparam logic [3:0] FIXED_LAST  = 4'd9;

	// flag bits kept from the flags byte
	localparam logic [4:0] FL_HCRC    = 5'h02;
	localparam logic [4:0] FL_EXTRA   = 5'h04;
	localparam logic [4:0] FL_NAME    = 5'h08;
	localparam logic [4:0] FL_COMMENT = 5'h10;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
	localparam logic [1:0] ST_BAD_METHOD = 2'd2;

	// one result beat
	typedef struct packed {
		logic        member_start;
		logic [31:0] start_offset;
		logic [15:0] member_number;
		logic [1:0]  status;
		logic        stream_end;
	} result_t;

endpackage

@@ hdl/gzmbf_parser.sv @@
module gzmbf_parser #(
	parameter int OFFSET_BITS = gzmbf_pkg::OFFSET_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output gzmbf_pkg::result_t  res
);

	typedef enum logic [2:0] {
		PH_MAGIC0,
		PH_MAGIC1,
		PH_METHOD,
		PH_FIXED,
		PH_XLEN,
		PH_SKIP,
		PH_ZSTR,
		PH_SCAN
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [3:0]             hpos_q, hpos_n;
	logic [4:0]             flags_q, flags_n;
	logic [16:0]            extra_q, extra_n;
	logic [15:0]            recent_q, recent_n;
	logic [1:0]             fill_q, fill_n;
	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	logic [15:0]            members_q, members_n;
	logic                   halted_q, halted_n;

	logic                   go_next;
	logic                   start;
	logic [1:0]             status;
	logic [OFFSET_BITS-1:0] soff;
	logic [OFFSET_BITS+31:0] soff_ext;

	// next state and result for the current byte
	always_comb begin
		phase_n   = phase_q;
		hpos_n    = hpos_q;
		flags_n   = flags_q;
		extra_n   = extra_q;
		recent_n  = recent_q;
		fill_n    = fill_q;
		offset_n  = offset_q;
		members_n = members_q;
		halted_n  = halted_q;
		go_next   = 1'b0;
		start     = 1'b0;
		status    = gzmbf_pkg::ST_OK;
		soff      = '0;

		if (halted_q) begin
			status = (phase_q == PH_METHOD) ? gzmbf_pkg::ST_BAD_METHOD
				: gzmbf_pkg::ST_BAD_MAGIC;
		end else begin
			unique case (phase_q)
				PH_MAGIC0: begin
					if (data_byte == gzmbf_pkg::MAGIC0) begin
						phase_n = PH_MAGIC1;
					end else begin
						halted_n = 1'b1;
						status   = gzmbf_pkg::ST_BAD_MAGIC;
					end
				end
				PH_MAGIC1: begin
					if (data_byte == gzmbf_pkg::MAGIC1) begin
						phase_n = PH_METHOD;
					end else begin
						halted_n = 1'b1;
						status   = gzmbf_pkg::ST_BAD_MAGIC;
					end
				end
				PH_METHOD: begin
					if (data_byte == gzmbf_pkg::METHOD_DEFL) begin
						if (members_q != 16'hffff) members_n = members_q + 16'd1;
						start   = 1'b1;
						soff    = offset_q - OFFSET_BITS'(2);
						phase_n = PH_FIXED;
						hpos_n  = gzmbf_pkg::FIXED_FLAGS;
					end else begin
						halted_n = 1'b1;
						status   = gzmbf_pkg::ST_BAD_METHOD;
					end
				end
				PH_FIXED: begin
					if (hpos_q == gzmbf_pkg::FIXED_FLAGS) flags_n = data_byte[4:0];
					if (hpos_q >= gzmbf_pkg::FIXED_LAST) go_next = 1'b1;
					else hpos_n = hpos_q + 4'd1;
				end
				PH_XLEN: begin
					if (hpos_q == 4'd0) begin
						extra_n = {9'd0, data_byte};
						hpos_n  = 4'd1;
					end else begin
						extra_n = extra_q | {1'b0, data_byte, 8'd0};
						if (extra_n == 17'd0) begin
							go_next = 1'b1;
						end else begin
							phase_n = PH_SKIP;
							hpos_n  = 4'd0;
						end
					end
				end
				PH_SKIP: begin
					if (extra_q != 17'd0) extra_n = extra_q - 17'd1;
					if (extra_n == 17'd0) go_next = 1'b1;
				end
				PH_ZSTR: begin
					if (data_byte == 8'd0) go_next = 1'b1;
				end
				PH_SCAN: begin
					if (fill_q == 2'd2 && recent_q == {gzmbf_pkg::MAGIC0, gzmbf_pkg::MAGIC1}
						&& data_byte == gzmbf_pkg::METHOD_DEFL) begin
						if (members_q != 16'hffff) members_n = members_q + 16'd1;
						start    = 1'b1;
						soff     = offset_q - OFFSET_BITS'(2);
						flags_n  = '0;
						phase_n  = PH_FIXED;
						hpos_n   = gzmbf_pkg::FIXED_FLAGS;
						recent_n = '0;
						fill_n   = '0;
					end else begin
						recent_n = {recent_q[7:0], data_byte};
						if (fill_q != 2'd2) fill_n = fill_q + 2'd1;
					end
				end
				default: ;
			endcase

			// advance to the next optional header section or to the scan
			if (go_next) begin
				hpos_n = 4'd0;
				priority if ((flags_n & gzmbf_pkg::FL_EXTRA) != 5'd0) begin
					flags_n = flags_n & ~gzmbf_pkg::FL_EXTRA;
					extra_n = '0;
					phase_n = PH_XLEN;
				end else if ((flags_n & gzmbf_pkg::FL_NAME) != 5'd0) begin
					flags_n = flags_n & ~gzmbf_pkg::FL_NAME;
					phase_n = PH_ZSTR;
				end else if ((flags_n & gzmbf_pkg::FL_COMMENT) != 5'd0) begin
					flags_n = flags_n & ~gzmbf_pkg::FL_COMMENT;
					phase_n = PH_ZSTR;
				end else if ((flags_n & gzmbf_pkg::FL_HCRC) != 5'd0) begin
					flags_n = flags_n & ~gzmbf_pkg::FL_HCRC;
					extra_n = 17'd2;
					phase_n = PH_SKIP;
				end else begin
					recent_n = '0;
					fill_n   = '0;
					phase_n  = PH_SCAN;
				end
			end

			offset_n = offset_q + OFFSET_BITS'(1);
		end

		// result beat, taken before the end-of-stream clear
		soff_ext          = {32'd0, soff};
		res.member_start  = start;
		res.start_offset  = soff_ext[31:0];
		res.member_number = members_n;
		res.status        = status;
		res.stream_end    = last_byte;

		// end of stream starts a fresh stream unless halted
		if (last_byte && !halted_n) begin
			phase_n   = PH_MAGIC0;
			hpos_n    = '0;
			flags_n   = '0;
			extra_n   = '0;
			recent_n  = '0;
			fill_n    = '0;
			offset_n  = '0;
			members_n = '0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC0;
			hpos_q    <= '0;
			flags_q   <= '0;
			extra_q   <= '0;
			recent_q  <= '0;
			fill_q    <= '0;
			offset_q  <= '0;
			members_q <= '0;
			halted_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q   <= phase_n;
			hpos_q    <= hpos_n;
			flags_q   <= flags_n;
			extra_q   <= extra_n;
			recent_q  <= recent_n;
			fill_q    <= fill_n;
			offset_q  <= offset_n;
			members_q <= members_n;
			halted_q  <= halted_n;
		end
	end

endmodule

@@ hdl/gzmbf_out_buf.sv @@
module gzmbf_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gzmbf_pkg::result_t in_res,
	output logic               out_valid,
	input  logic               out_ready,
	output gzmbf_pkg::result_t out_res
);

	logic               out_valid_q;
	logic               skid_valid_q;
	gzmbf_pkg::result_t out_q;
	gzmbf_pkg::result_t skid_q;
	logic               in_fire;
	logic               out_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_fire) out_q <= in_res;
		end else if (in_fire) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ hdl/gzip_member_boundary_finder_core.sv @@
// a result beat is computed combinationally and registered in the output buffer when its input beat is accepted
// throughput: one byte per cycle while the skid entry is empty; the state update is a single registered step
// a two-entry output buffer (output register plus skid entry) takes one more input byte after the output stalls
// reset: arst_n clears all parser state and empties the output buffer
// after a final byte the stream state returns to reset unless halted
module gzip_member_boundary_finder_core #(
	parameter int OFFSET_BITS = gzmbf_pkg::OFFSET_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        member_start,
	output logic [31:0] start_offset,
	output logic [15:0] member_number,
	output logic [1:0]  status,
	output logic        stream_end
);

	gzmbf_pkg::result_t next_res;
	gzmbf_pkg::result_t out_res;
	logic               in_fire;

	assign in_fire = in_valid && in_ready;

	// header parser and signature scan
	gzmbf_parser #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res       (next_res)
	);

	// result register with skid entry
	gzmbf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_res    (next_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign member_start  = out_res.member_start;
	assign start_offset  = out_res.start_offset;
	assign member_number = out_res.member_number;
	assign status        = out_res.status;
	assign stream_end    = out_res.stream_end;

endmodule

@@ dv/tb_gzip_member_boundary_finder_core.sv @@
module tb_gzip_member_boundary_finder_core;

	// parser position inside a member
	typedef enum logic [2:0] {
		P_MAGIC0, P_MAGIC1, P_METHOD, P_FIXED, P_XLEN, P_SKIP, P_ZSTR, P_SCAN
	} parse_phase_t;

	// one planned input beat
	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} plan_beat_t;

	// tracks the stream, predicts every result beat and checks it
	class boundary_tracker;
		parse_phase_t        phase;
		logic [3:0]          hdr_pos;
		logic [4:0]          flags;
		logic [16:0]         extra_left;
		logic [15:0]         last_two;
		logic [1:0]          fill;
		logic [31:0]         offset;
		logic [15:0]         members;
		bit                  halted;
		gzmbf_pkg::result_t  expected_beats[$];
		int                  mismatches;

		function new();
			clear_stream();
			halted = 1'b0;
			mismatches = 0;
		endfunction

		function void clear_stream();
			phase = P_MAGIC0;
			hdr_pos = '0;
			flags = '0;
			extra_left = '0;
			last_two = '0;
			fill = '0;
			offset = '0;
			members = '0;
		endfunction

		// step to the next optional header section, or start scanning
		function void next_section();
			hdr_pos = '0;
			if (flags & gzmbf_pkg::FL_EXTRA) begin
				flags &= ~gzmbf_pkg::FL_EXTRA;
				extra_left = '0;
				phase = P_XLEN;
			end else if (flags & gzmbf_pkg::FL_NAME) begin
				flags &= ~gzmbf_pkg::FL_NAME;
				phase = P_ZSTR;
			end else if (flags & gzmbf_pkg::FL_COMMENT) begin
				flags &= ~gzmbf_pkg::FL_COMMENT;
				phase = P_ZSTR;
			end else if (flags & gzmbf_pkg::FL_HCRC) begin
				flags &= ~gzmbf_pkg::FL_HCRC;
				extra_left = 17'd2;
				phase = P_SKIP;
			end else begin
				last_two = '0;
				fill = '0;
				phase = P_SCAN;
			end
		endfunction

		function void count_member();
			if (members != 16'hffff)
				members = members + 16'd1;
		endfunction

		function gzmbf_pkg::result_t predict_byte(input logic [7:0] b, input logic l);
			gzmbf_pkg::result_t r;
			r = '0;
			r.status = gzmbf_pkg::ST_OK;
			if (halted) begin
				r.status = (phase == P_METHOD) ? gzmbf_pkg::ST_BAD_METHOD
					: gzmbf_pkg::ST_BAD_MAGIC;
			end else begin
				case (phase)
				P_MAGIC0: begin
					if (b == gzmbf_pkg::MAGIC0) phase = P_MAGIC1;
					else begin
						halted = 1'b1;
						r.status = gzmbf_pkg::ST_BAD_MAGIC;
					end
				end
				P_MAGIC1: begin
					if (b == gzmbf_pkg::MAGIC1) phase = P_METHOD;
					else begin
						halted = 1'b1;
						r.status = gzmbf_pkg::ST_BAD_MAGIC;
					end
				end
				P_METHOD: begin
					if (b == gzmbf_pkg::METHOD_DEFL) begin
						count_member();
						r.member_start = 1'b1;
						r.start_offset = offset - 32'd2;
						phase = P_FIXED;
						hdr_pos = gzmbf_pkg::FIXED_FLAGS;
					end else begin
						halted = 1'b1;
						r.status = gzmbf_pkg::ST_BAD_METHOD;
					end
				end
				P_FIXED: begin
					if (hdr_pos == gzmbf_pkg::FIXED_FLAGS)
						flags = b[4:0];
					if (hdr_pos >= gzmbf_pkg::FIXED_LAST) next_section();
					else hdr_pos = hdr_pos + 4'd1;
				end
				P_XLEN: begin
					if (hdr_pos == 4'd0) begin
						extra_left = {9'd0, b};
						hdr_pos = 4'd1;
					end else begin
						extra_left = extra_left | {1'b0, b, 8'h00};
						if (extra_left == '0) next_section();
						else begin
							phase = P_SKIP;
							hdr_pos = '0;
						end
					end
				end
				P_SKIP: begin
					if (extra_left != '0)
						extra_left = extra_left - 17'd1;
					if (extra_left == '0)
						next_section();
				end
				P_ZSTR: begin
					if (b == 8'h00)
						next_section();
				end
				default: begin
					// signature counts only when all three bytes came after the header
					if (fill >= 2'd2
						&& last_two == {gzmbf_pkg::MAGIC0, gzmbf_pkg::MAGIC1}
						&& b == gzmbf_pkg::METHOD_DEFL) begin
						count_member();
						r.member_start = 1'b1;
						r.start_offset = offset - 32'd2;
						flags = '0;
						phase = P_FIXED;
						hdr_pos = gzmbf_pkg::FIXED_FLAGS;
						last_two = '0;
						fill = '0;
					end else begin
						last_two = {last_two[7:0], b};
						if (fill < 2'd2)
							fill = fill + 2'd1;
					end
				end
				endcase
				offset = offset + 32'd1;
			end
			r.member_number = members;
			r.stream_end = l;
			if (l && !halted)
				clear_stream();
			return r;
		endfunction

		function void note_byte(input logic [7:0] b, input logic l);
			expected_beats.insert(expected_beats.size(), predict_byte(b, l));
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_beat(input gzmbf_pkg::result_t got);
			gzmbf_pkg::result_t want;
			if (expected_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = expected_beats.pop_front();
				if (got.member_start !== want.member_start)
					report_mismatch($sformatf("member_start %0b, want %0b",
						got.member_start, want.member_start));
				if (got.start_offset !== want.start_offset)
					report_mismatch($sformatf("start_offset %0d, want %0d",
						got.start_offset, want.start_offset));
				if (got.member_number !== want.member_number)
					report_mismatch($sformatf("member_number %0d, want %0d",
						got.member_number, want.member_number));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.stream_end !== want.stream_end)
					report_mismatch($sformatf("stream_end %0b, want %0b",
						got.stream_end, want.stream_end));
			end
		endtask
	endclass

	localparam int LONG_STALL = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        member_start;
	logic [31:0] start_offset;
	logic [15:0] member_number;
	logic [1:0]  status;
	logic        stream_end;

	boundary_tracker sb = new();
	plan_beat_t      byte_plan[$];
	int              bytes_sent = 0;
	int              send_gap_pct = 20;
	int              recv_gap_pct = 59;
	bit              long_stall_req = 1'b0;
	bit              long_stall_done = 1'b0;

	gzip_member_boundary_finder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.member_start(member_start),
		.start_offset(start_offset),
		.member_number(member_number),
		.status(status),
		.stream_end(stream_end)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	initial begin
		#(12 * 300000);
		$display("tb_gzip_member_boundary_finder_core: done, errors");
		$finish;
	end

	// receiver: random backpressure plus one long hold-off on request
	initial begin
		int stall_cnt;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req && !long_stall_done) begin
				out_ready <= 1'b0;
				stall_cnt = 0;
				while (stall_cnt < LONG_STALL) begin
					@(posedge clk);
					stall_cnt++;
				end
				long_stall_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat('{member_start, start_offset, member_number, status, stream_end});
	end

	// offer one beat and wait for it to be taken
	task automatic offer_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b, l);
		bytes_sent++;
	endtask

	task automatic send_plan();
		plan_beat_t pb;
		while (byte_plan.size() != 0) begin
			pb = byte_plan.pop_front();
			offer_byte(pb.value, pb.is_last);
		end
	endtask

	function automatic void plan_byte(input logic [7:0] b);
		plan_beat_t pb;
		pb.value = b;
		pb.is_last = 1'b0;
		byte_plan.insert(byte_plan.size(), pb);
	endfunction

	function automatic void mark_stream_end();
		byte_plan[byte_plan.size() - 1].is_last = 1'b1;
	endfunction

	// body bytes lean toward signature bytes so partial matches are common
	function automatic logic [7:0] body_byte();
		case ($urandom_range(9))
		0: return gzmbf_pkg::MAGIC0;
		1: return gzmbf_pkg::MAGIC1;
		2: return gzmbf_pkg::METHOD_DEFL;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void plan_zstring();
		int n;
		n = $urandom_range(6);
		repeat (n) plan_byte(8'($urandom_range(255, 1)));
		plan_byte(8'h00);
	endfunction

	// well-formed member header with random flags and contents
	function automatic void plan_header();
		logic [7:0] flg;
		int         pick;
		int         xlen;
		flg = 8'($urandom_range(255));
		plan_byte(gzmbf_pkg::MAGIC0);
		plan_byte(gzmbf_pkg::MAGIC1);
		plan_byte(gzmbf_pkg::METHOD_DEFL);
		plan_byte(flg);
		repeat (6) plan_byte(8'($urandom_range(255)));
		if (flg[4:0] & gzmbf_pkg::FL_EXTRA) begin
			pick = $urandom_range(99);
			if (pick < 70) xlen = $urandom_range(6);
			else if (pick < 95) xlen = $urandom_range(40, 7);
			else xlen = $urandom_range(300, 41);
			plan_byte(xlen[7:0]);
			plan_byte(xlen[15:8]);
			repeat (xlen) plan_byte(body_byte());
		end
		if (flg[4:0] & gzmbf_pkg::FL_NAME)
			plan_zstring();
		if (flg[4:0] & gzmbf_pkg::FL_COMMENT)
			plan_zstring();
		if (flg[4:0] & gzmbf_pkg::FL_HCRC) begin
			plan_byte(body_byte());
			plan_byte(body_byte());
		end
	endfunction

	// one stream of 1..4 members, sometimes cut short anywhere
	function automatic void plan_random_stream();
		int nmem;
		int blen;
		int cut;
		nmem = $urandom_range(4, 1);
		for (int m = 0; m < nmem; m++) begin
			plan_header();
			blen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(24);
			repeat (blen) plan_byte(body_byte());
		end
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(byte_plan.size() - 1);
			repeat (cut) void'(byte_plan.pop_back());
		end
		mark_stream_end();
	endfunction

	initial begin
		logic [7:0] hdr_seq[22];
		logic [7:0] b;
		int         drain_cnt;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stream that ends on its very first byte
		plan_byte(gzmbf_pkg::MAGIC0);
		mark_stream_end();
		send_plan();

		// all four tracked flag bits set (flags byte 0xfe), empty extra field, header crc bytes that look like
		// a signature start, then a signature ending on the final byte
		hdr_seq = '{8'h1f, 8'h8b, 8'h08, 8'hfe, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
			8'h00, 8'h00, 8'h41, 8'h00, 8'h00, 8'h1f, 8'h8b,
			8'h08, 8'h1f, 8'h1f, 8'h8b, 8'h08};
		foreach (hdr_seq[i]) plan_byte(hdr_seq[i]);
		mark_stream_end();
		send_plan();

		// random streams over three backpressure mixes
		while (bytes_sent < 1800) begin
			if (bytes_sent >= 1200) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end else if (bytes_sent >= 600) begin
				send_gap_pct = 59;
				recv_gap_pct = 20;
			end
			if (bytes_sent >= 900)
				long_stall_req = 1'b1;
			plan_random_stream();
			send_plan();
		end

		// broken first header last, since it halts the block for good
		b = 8'($urandom_range(255));
		case ($urandom_range(2))
		0: begin
			// bad first magic byte
			plan_byte((b == gzmbf_pkg::MAGIC0) ? ~b : b);
		end
		1: begin
			// bad second magic byte
			plan_byte(gzmbf_pkg::MAGIC0);
			plan_byte((b == gzmbf_pkg::MAGIC1) ? ~b : b);
		end
		default: begin
			// bad compression method
			plan_byte(gzmbf_pkg::MAGIC0);
			plan_byte(gzmbf_pkg::MAGIC1);
			plan_byte((b == gzmbf_pkg::METHOD_DEFL) ? ~b : b);
		end
		endcase
		repeat (12) begin
			plan_byte(8'($urandom_range(255)));
			if ($urandom_range(2) == 0)
				mark_stream_end();
		end
		send_plan();
		in_valid <= 1'b0;

		// drain
		drain_cnt = 0;
		while (sb.pending() != 0 && drain_cnt < 5000) begin
			@(posedge clk);
			drain_cnt++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d result beats never arrived", sb.pending()));

		if (sb.mismatches == 0)
			$display("tb_gzip_member_boundary_finder_core: done, clean");
		else
			$display("tb_gzip_member_boundary_finder_core: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/gzmbf_pkg.sv
hdl/gzmbf_parser.sv
hdl/gzmbf_out_buf.sv
hdl/gzip_member_boundary_finder_core.sv
dv/tb_gzip_member_boundary_finder_core.sv
